// ===== src/tfn_pkg.sv =====
// Shared types for the triangle face normal pipeline.
package tfn_pkg;

  typedef struct packed {
    logic neg;   // component of the cross product is negative
    logic zero;  // cross product is zero
  } tfn_side_t;

endpackage

// ===== src/tfn_lane.sv =====
// One normal component: pipelined restoring divide of c^2 by S, then pipelined square root.
module tfn_lane #(
  parameter int SW = 104,
  parameter int F  = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SW-1:0]          c2_i,
  input  logic [SW-1:0]          s_i,
  input  tfn_pkg::tfn_side_t     side_i,
  output logic signed [F+1:0]    normal_o,
  output logic                   deg_o
);

  localparam int QW  = 2 * F + 1;  // quotient bits
  localparam int RW  = F + 1;      // root bits
  localparam int RDW = 2 * RW;     // padded radicand
  localparam int RMW = RW + 3;     // square root remainder

  // divide stages
  logic [SW-1:0]       r_q  [QW];
  logic [SW-1:0]       s_q  [QW];
  logic [QW-1:0]       q_q  [QW];
  tfn_pkg::tfn_side_t  sd_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [SW:0]        t;
    logic [SW:0]        diff;
    logic [SW-1:0]      s_src;
    logic [QW-1:0]      q_src;
    tfn_pkg::tfn_side_t sd_src;
    logic               ge;

    if (g == 0) begin : g_first
      assign t      = {1'b0, c2_i};
      assign s_src  = s_i;
      assign q_src  = '0;
      assign sd_src = side_i;
    end else begin : g_next
      assign t      = {r_q[g-1], 1'b0};
      assign s_src  = s_q[g-1];
      assign q_src  = q_q[g-1];
      assign sd_src = sd_q[g-1];
    end

    assign ge   = t >= {1'b0, s_src};
    assign diff = t - {1'b0, s_src};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]  <= ge ? diff[SW-1:0] : t[SW-1:0];
        s_q[g]  <= s_src;
        q_q[g]  <= {q_src[QW-2:0], ge};
        sd_q[g] <= sd_src;
      end
    end
  end

  // square root stages, two radicand bits per stage
  logic [RDW-1:0]      rad_q  [RW];
  logic [RMW-1:0]      rem_q  [RW];
  logic [RW-1:0]       root_q [RW];
  tfn_pkg::tfn_side_t  rs_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RDW-1:0]     rad_src;
    logic [RMW-1:0]     rem_src;
    logic [RW-1:0]      root_src;
    tfn_pkg::tfn_side_t sd_src;
    logic [RMW+1:0]     t;
    logic [RMW+1:0]     trial;
    logic [RMW+1:0]     diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_src  = {1'b0, q_q[QW-1]};
      assign rem_src  = '0;
      assign root_src = '0;
      assign sd_src   = sd_q[QW-1];
    end else begin : g_next
      assign rad_src  = rad_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign sd_src   = rs_q[k-1];
    end

    assign t     = {rem_src, rad_src[RDW-1:RDW-2]};
    assign trial = (RMW+2)'({root_src, 2'b01});
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_src[RDW-3:0], 2'b00};
        rem_q[k]  <= ge ? diff[RMW-1:0] : t[RMW-1:0];
        root_q[k] <= {root_src[RW-2:0], ge};
        rs_q[k]   <= sd_src;
      end
    end
  end

  logic [F+1:0] mag;
  assign mag = (F+2)'(root_q[RW-1]);

  // apply sign, force zero for a degenerate triangle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rs_q[RW-1].zero) begin
        normal_o <= '0;
      end else if (rs_q[RW-1].neg) begin
        normal_o <= -$signed(mag);
      end else begin
        normal_o <= $signed(mag);
      end
      deg_o <= rs_q[RW-1].zero;
    end
  end

endmodule

// ===== src/triangle_face_normal_top.sv =====
// Top level of the triangle unit face normal pipeline.
// Takes one triangle (three vertices of signed fixed-point coordinates) per
// cycle and returns its unit face normal in signed Q1.NORMAL_FRAC_BITS,
// rounded toward zero, with a zero normal and degenerate_o set when the cross
// product is zero. The pipeline has six front stages for edges, cross
// product, squares and their sum, 2*NORMAL_FRAC_BITS+1 restoring divide
// stages of c^2 by the squared length, NORMAL_FRAC_BITS+1 square root stages
// and one output register. Throughput is one triangle per cycle; a stall on
// the output freezes the whole pipeline.
module triangle_face_normal_top #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  v0_x_i,
  input  logic signed [COORD_BITS-1:0]  v0_y_i,
  input  logic signed [COORD_BITS-1:0]  v0_z_i,
  input  logic signed [COORD_BITS-1:0]  v1_x_i,
  input  logic signed [COORD_BITS-1:0]  v1_y_i,
  input  logic signed [COORD_BITS-1:0]  v1_z_i,
  input  logic signed [COORD_BITS-1:0]  v2_x_i,
  input  logic signed [COORD_BITS-1:0]  v2_y_i,
  input  logic signed [COORD_BITS-1:0]  v2_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                          degenerate_o
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int EW  = COORD_BITS + 1;   // edge
  localparam int PW  = 2 * EW;           // product
  localparam int CW  = PW + 1;           // cross component, signed
  localparam int CM  = CW;               // its magnitude
  localparam int H   = (CM + 1) / 2;     // low half of magnitude
  localparam int HW  = CM - H;           // high half
  localparam int C2W = 2 * CM;
  localparam int SW  = C2W + 2;
  localparam int LAT = 3 * F + 3;        // lane stages
  localparam int NST = 6 + LAT;
  localparam logic signed [F+1:0] ONE = (F+2)'(1) <<< F;

  logic en;
  logic [NST-1:0] vld_q;

  assign en          = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: edges e1 = v1 - v0, e2 = v2 - v0 (x, y, z, then x, y, z)
  logic signed [EW-1:0] e_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= EW'(v1_x_i) - EW'(v0_x_i);
      e_q[1] <= EW'(v1_y_i) - EW'(v0_y_i);
      e_q[2] <= EW'(v1_z_i) - EW'(v0_z_i);
      e_q[3] <= EW'(v2_x_i) - EW'(v0_x_i);
      e_q[4] <= EW'(v2_y_i) - EW'(v0_y_i);
      e_q[5] <= EW'(v2_z_i) - EW'(v0_z_i);
    end
  end

  // stage 2: the six cross product terms
  logic signed [PW-1:0] p_q [6];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW'(e_q[1]) * PW'(e_q[5]);
      p_q[1] <= PW'(e_q[2]) * PW'(e_q[4]);
      p_q[2] <= PW'(e_q[2]) * PW'(e_q[3]);
      p_q[3] <= PW'(e_q[0]) * PW'(e_q[5]);
      p_q[4] <= PW'(e_q[0]) * PW'(e_q[4]);
      p_q[5] <= PW'(e_q[1]) * PW'(e_q[3]);
    end
  end

  // stage 3: cross components as sign and magnitude
  logic [CM-1:0] mag_q [3];
  logic [2:0]    neg3_q;
  for (genvar i = 0; i < 3; i++) begin : g_cross
    logic signed [CW-1:0] cd;
    assign cd = CW'(p_q[2*i]) - CW'(p_q[2*i+1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[i]  <= cd[CW-1] ? CM'(-cd) : CM'(cd);
        neg3_q[i] <= cd[CW-1];
      end
    end
  end

  // stage 4: partial products of the squares; stage 5: the squares
  logic [2*HW-1:0]   hh_q [3];
  logic [HW+H-1:0]   hl_q [3];
  logic [2*H-1:0]    ll_q [3];
  logic [2:0]        neg4_q, neg5_q, neg6_q;
  logic [C2W-1:0]    c2_q [3];
  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [HW-1:0] hi;
    logic [H-1:0]  lo;
    assign hi = mag_q[i][CM-1:H];
    assign lo = mag_q[i][H-1:0];
    always_ff @(posedge clk_i) begin
      if (en) begin
        hh_q[i] <= (2*HW)'(hi) * (2*HW)'(hi);
        hl_q[i] <= (HW+H)'(hi) * (HW+H)'(lo);
        ll_q[i] <= (2*H)'(lo) * (2*H)'(lo);
        c2_q[i] <= (C2W'(hh_q[i]) << (2*H)) + (C2W'(hl_q[i]) << (H+1)) + C2W'(ll_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q <= neg3_q;
      neg5_q <= neg4_q;
      neg6_q <= neg5_q;
    end
  end

  // stage 6: squared length
  logic [SW-1:0] s_d, s_q;
  logic [SW-1:0] c2s_q [3];
  logic          zero_q;
  assign s_d = SW'(c2_q[0]) + SW'(c2_q[1]) + SW'(c2_q[2]);
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q    <= s_d;
      zero_q <= (s_d == '0);
      for (int i = 0; i < 3; i++) begin
        c2s_q[i] <= SW'(c2_q[i]);
      end
    end
  end

  logic signed [F+1:0] nrm [3];
  logic                deg;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tfn_pkg::tfn_side_t side;
    assign side.neg  = neg6_q[i];
    assign side.zero = zero_q;
    if (i == 0) begin : g_flag
      tfn_lane #(.SW(SW), .F(F)) u_lane (
        .clk_i, .en_i(en), .c2_i(c2s_q[i]), .s_i(s_q), .side_i(side),
        .normal_o(nrm[i]), .deg_o(deg)
      );
    end else begin : g_noflag
      tfn_lane #(.SW(SW), .F(F)) u_lane (
        .clk_i, .en_i(en), .c2_i(c2s_q[i]), .s_i(s_q), .side_i(side),
        .normal_o(nrm[i]), .deg_o()
      );
    end
  end

  assign normal_x_o   = nrm[0];
  assign normal_y_o   = nrm[1];
  assign normal_z_o   = nrm[2];
  assign degenerate_o = deg;

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      normal_x_o <= ONE && normal_x_o >= -ONE &&
      normal_y_o <= ONE && normal_y_o >= -ONE &&
      normal_z_o <= ONE && normal_z_o >= -ONE)
    else $error("normal component exceeds one");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |->
      normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
    else $error("regular triangle gave a zero normal");
`endif

endmodule
